// ----- hw/rtl/rule30_feistel_block_cipher_defines.svh -----
// Assertion macros for the rule-30 Feistel block cipher.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef RULE30_FEISTEL_BLOCK_CIPHER_DEFINES_SVH
`define RULE30_FEISTEL_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define R30FC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("r30fc assertion failed");
// next-cycle implication
`define R30FC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("r30fc assertion failed");
`else
`define R30FC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define R30FC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/r30fc_pkg.sv -----
// Shared types and constants of the rule-30 Feistel block cipher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r30fc_pkg;

  localparam int WORD_W          = 32;
  localparam int BLOCK_W         = 64;
  localparam int KEY_W           = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int ROUND_KEY_COUNT = 32;
  localparam int WHITEN_COUNT    = 4;
  localparam int MIX_WORDS       = 4;
  localparam int GENERATIONS     = 5;
  localparam int STIR_COUNT      = WHITEN_COUNT + ROUND_KEY_COUNT;
  localparam int CNT_W           = $clog2(STIR_COUNT);
  localparam int STEP_W          = 3;
  localparam int MIX_IDX_W       = $clog2(MIX_WORDS);
  localparam int KEY_TAP_HI      = 7;
  localparam int KEY_TAP_LO      = ROUND_KEY_COUNT - 5;

  // sub-steps of one stir pass
  localparam logic [STEP_W-1:0] STEP_M0  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_M1  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_M2  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_M3  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_OUT = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_INIT,
    ST_STIR,
    ST_SCHED_W,
    ST_SCHED_K,
    ST_WHITEN,
    ST_ROUND,
    ST_FINAL
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_IN,
    OP_MIX_INIT,
    OP_STIR,
    OP_SCHED_W,
    OP_SCHED_K,
    OP_WHITEN,
    OP_ROUND,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [MIX_IDX_W-1:0]  mix_idx;
    logic [STEP_W-1:0]     stir_step;
    logic                  to_w;
    logic                  last;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/r30fc_round.sv -----
// Round function: key XOR then five generations of circular rule-30.
// Depends on r30fc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r30fc_round (
  input  wire r30fc_pkg::word_t half,
  input  wire r30fc_pkg::word_t key,
  output r30fc_pkg::word_t      y
);
  import r30fc_pkg::*;

  word_t v;

  always_comb begin
    v = half ^ key;
    for (int g = 0; g < GENERATIONS; g++) begin
      v = {v[WORD_W-2:0], v[WORD_W-1]} ^ (v | {v[0], v[WORD_W-1:1]});
    end
  end

  assign y = v;

endmodule

`default_nettype wire

// ----- hw/rtl/r30fc_dp.sv -----
// Datapath: config registers, key-cycle storage, mixing words, Feistel halves.
// Depends on r30fc_pkg and r30fc_round.
`timescale 1ns / 1ps
`default_nettype none

module r30fc_dp (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [r30fc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [r30fc_pkg::KEY_W-1:0]      cfg_data,
  input  wire [r30fc_pkg::BLOCK_W-1:0]    in_block,
  input  wire r30fc_pkg::cmd_t            cmd,
  output logic [r30fc_pkg::BLOCK_W-1:0]   result_block
);
  import r30fc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd4;

  localparam logic [MIX_IDX_W-1:0] MIX0 = 2'd0;
  localparam logic [MIX_IDX_W-1:0] MIX1 = 2'd1;
  localparam logic [MIX_IDX_W-1:0] MIX2 = 2'd2;

  logic [KEY_W-1:0] key0_r, key1_r, key2_r, key3_r;
  logic [KEY_W-1:0] key0_nxt, key1_nxt, key2_nxt, key3_nxt;
  logic             mode_r, mode_nxt;

  word_t m0_r, m1_r, m2_r, m3_r;
  word_t m0_nxt, m1_nxt, m2_nxt, m3_nxt;
  word_t w_r   [WHITEN_COUNT];
  word_t w_nxt [WHITEN_COUNT];
  word_t wn_r   [WHITEN_COUNT-1];
  word_t wn_nxt [WHITEN_COUNT-1];
  word_t k_r   [ROUND_KEY_COUNT];
  word_t k_nxt [ROUND_KEY_COUNT];
  word_t kn_r   [ROUND_KEY_COUNT-1];
  word_t kn_nxt [ROUND_KEY_COUNT-1];
  word_t l_r, r_r, l_nxt, r_nxt;
  logic [BLOCK_W-1:0] result_r, result_nxt;

  word_t fn_a, fn_b, fn_y;

  r30fc_round u_round (
    .half (fn_a),
    .key  (fn_b),
    .y    (fn_y)
  );

  // operand select for the shared round unit
  always_comb begin
    fn_a = l_r;
    fn_b = k_r[0];
    case (cmd.op)
      OP_MIX_INIT: begin
        case (cmd.mix_idx)
          MIX0: begin
            fn_a = key0_r[KEY_W-1:WORD_W];
            fn_b = key1_r[WORD_W-1:0];
          end
          MIX1: begin
            fn_a = key1_r[KEY_W-1:WORD_W];
            fn_b = key2_r[WORD_W-1:0];
          end
          MIX2: begin
            fn_a = key2_r[KEY_W-1:WORD_W];
            fn_b = key3_r[WORD_W-1:0];
          end
          default: begin
            fn_a = key3_r[KEY_W-1:WORD_W];
            fn_b = key0_r[WORD_W-1:0];
          end
        endcase
      end
      OP_STIR: begin
        case (cmd.stir_step)
          STEP_M0: begin
            fn_a = m2_r;
            fn_b = m1_r;
          end
          STEP_M1: begin
            fn_a = m3_r;
            fn_b = m2_r;
          end
          STEP_M2: begin
            fn_a = m0_r;
            fn_b = m3_r;
          end
          STEP_M3: begin
            fn_a = m1_r;
            fn_b = m0_r;
          end
          default: begin
            fn_a = m0_r;
            fn_b = m1_r;
          end
        endcase
      end
      OP_SCHED_W: begin
        fn_a = w_r[1];
        fn_b = w_r[0];
      end
      OP_SCHED_K: begin
        fn_a = k_r[KEY_TAP_HI];
        fn_b = k_r[KEY_TAP_LO];
      end
      OP_ROUND: begin
        fn_a = l_r;
        fn_b = mode_r ? k_r[ROUND_KEY_COUNT-1] : k_r[0];
      end
      default: begin
        fn_a = l_r;
        fn_b = k_r[0];
      end
    endcase
  end

  // config registers
  always_comb begin
    key0_nxt = key0_r;
    key1_nxt = key1_r;
    key2_nxt = key2_r;
    key3_nxt = key3_r;
    mode_nxt = mode_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key0_nxt = cfg_data;
        REG_KEY1: key1_nxt = cfg_data;
        REG_KEY2: key2_nxt = cfg_data;
        REG_KEY3: key3_nxt = cfg_data;
        REG_MODE: mode_nxt = cfg_data[0];
        default:  mode_nxt = mode_r;
      endcase
    end
  end

  // key cycle, mixing words and block halves
  always_comb begin
    m0_nxt     = m0_r;
    m1_nxt     = m1_r;
    m2_nxt     = m2_r;
    m3_nxt     = m3_r;
    w_nxt      = w_r;
    wn_nxt     = wn_r;
    k_nxt      = k_r;
    kn_nxt     = kn_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    result_nxt = result_r;
    case (cmd.op)
      OP_LOAD_IN: begin
        l_nxt = in_block[BLOCK_W-1:WORD_W];
        r_nxt = in_block[WORD_W-1:0];
      end
      OP_MIX_INIT: begin
        case (cmd.mix_idx)
          MIX0:    m0_nxt = fn_y;
          MIX1:    m1_nxt = fn_y;
          MIX2:    m2_nxt = fn_y;
          default: m3_nxt = fn_y;
        endcase
      end
      OP_STIR: begin
        case (cmd.stir_step)
          STEP_M0: m0_nxt = fn_y;
          STEP_M1: m1_nxt = fn_y;
          STEP_M2: m2_nxt = fn_y;
          STEP_M3: m3_nxt = fn_y;
          default: begin
            if (cmd.to_w) begin
              for (int j = 0; j < WHITEN_COUNT - 1; j++) w_nxt[j] = w_r[j+1];
              w_nxt[WHITEN_COUNT-1] = fn_y;
            end else begin
              for (int j = 0; j < ROUND_KEY_COUNT - 1; j++) k_nxt[j] = k_r[j+1];
              k_nxt[ROUND_KEY_COUNT-1] = fn_y;
            end
          end
        endcase
      end
      OP_SCHED_W: begin
        for (int j = 0; j < WHITEN_COUNT - 2; j++) wn_nxt[j] = wn_r[j+1];
        wn_nxt[WHITEN_COUNT-2] = fn_y;
        if (cmd.last) begin
          for (int j = 0; j < WHITEN_COUNT - 1; j++) w_nxt[j] = wn_r[j];
          w_nxt[WHITEN_COUNT-1] = fn_y;
        end else begin
          for (int j = 0; j < WHITEN_COUNT; j++) w_nxt[j] = w_r[(j + 1) % WHITEN_COUNT];
        end
      end
      OP_SCHED_K: begin
        for (int j = 0; j < ROUND_KEY_COUNT - 2; j++) kn_nxt[j] = kn_r[j+1];
        kn_nxt[ROUND_KEY_COUNT-2] = fn_y;
        if (cmd.last) begin
          for (int j = 0; j < ROUND_KEY_COUNT - 1; j++) k_nxt[j] = kn_r[j];
          k_nxt[ROUND_KEY_COUNT-1] = fn_y;
        end else begin
          for (int j = 0; j < ROUND_KEY_COUNT; j++) begin
            k_nxt[j] = k_r[(j + 1) % ROUND_KEY_COUNT];
          end
        end
      end
      OP_WHITEN: begin
        l_nxt = l_r ^ (mode_r ? w_r[3] : w_r[0]);
        r_nxt = r_r ^ (mode_r ? w_r[2] : w_r[1]);
      end
      OP_ROUND: begin
        l_nxt = r_r ^ fn_y;
        r_nxt = l_r;
        // encrypt walks keys upward, decrypt downward
        for (int j = 0; j < ROUND_KEY_COUNT; j++) begin
          if (mode_r) k_nxt[j] = k_r[(j + ROUND_KEY_COUNT - 1) % ROUND_KEY_COUNT];
          else        k_nxt[j] = k_r[(j + 1) % ROUND_KEY_COUNT];
        end
      end
      OP_FINAL: begin
        result_nxt = {r_r ^ (mode_r ? w_r[0] : w_r[3]),
                      l_r ^ (mode_r ? w_r[1] : w_r[2])};
      end
      default: begin
        result_nxt = result_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      mode_r <= 1'b0;
    end else begin
      key0_r <= key0_nxt;
      key1_r <= key1_nxt;
      key2_r <= key2_nxt;
      key3_r <= key3_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m0_r     <= m0_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    m3_r     <= m3_nxt;
    w_r      <= w_nxt;
    wn_r     <= wn_nxt;
    k_r      <= k_nxt;
    kn_r     <= kn_nxt;
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    result_r <= result_nxt;
  end

  assign result_block = result_r;

endmodule

`default_nettype wire

// ----- hw/rtl/r30fc_ctrl.sv -----
// Controller FSM: sequences derivation, scheduling, rounds and result transfer.
// Depends on r30fc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r30fc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  input  wire              in_tuser,
  output logic             in_tready,
  input  wire              out_tready,
  output logic             out_tvalid,
  output r30fc_pkg::cmd_t  cmd
);
  import r30fc_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                cycle_valid_r, cycle_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_xfer;
  logic                out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    step_nxt        = step_r;
    cycle_valid_nxt = cycle_valid_r;
    out_valid_nxt   = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_nxt = '0;
          if (in_tuser || !cycle_valid_r) state_nxt = ST_MIX_INIT;
          else                            state_nxt = ST_SCHED_W;
        end
      end
      ST_MIX_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MIX_WORDS - 1)) begin
          state_nxt = ST_STIR;
          cnt_nxt   = '0;
          step_nxt  = STEP_M0;
        end
      end
      ST_STIR: begin
        if (step_r == STEP_OUT) begin
          step_nxt = STEP_M0;
          cnt_nxt  = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STIR_COUNT - 1)) begin
            state_nxt       = ST_SCHED_W;
            cnt_nxt         = '0;
            cycle_valid_nxt = 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SCHED_W: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WHITEN_COUNT - 1)) begin
          state_nxt = ST_SCHED_K;
          cnt_nxt   = '0;
        end
      end
      ST_SCHED_K: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROUND_KEY_COUNT - 1)) begin
          state_nxt = ST_WHITEN;
          cnt_nxt   = '0;
        end
      end
      ST_WHITEN: begin
        state_nxt = ST_ROUND;
        cnt_nxt   = '0;
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROUND_KEY_COUNT - 1)) begin
          state_nxt = ST_FINAL;
          cnt_nxt   = '0;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op        = OP_NOP;
    cmd.mix_idx   = cnt_r[MIX_IDX_W-1:0];
    cmd.stir_step = step_r;
    cmd.to_w      = (cnt_r < CNT_W'(WHITEN_COUNT));
    cmd.last      = 1'b0;
    case (state_r)
      ST_IDLE:     if (in_xfer) cmd.op = OP_LOAD_IN;
      ST_MIX_INIT: cmd.op = OP_MIX_INIT;
      ST_STIR:     cmd.op = OP_STIR;
      ST_SCHED_W: begin
        cmd.op   = OP_SCHED_W;
        cmd.last = (cnt_r == CNT_W'(WHITEN_COUNT - 1));
      end
      ST_SCHED_K: begin
        cmd.op   = OP_SCHED_K;
        cmd.last = (cnt_r == CNT_W'(ROUND_KEY_COUNT - 1));
      end
      ST_WHITEN:   cmd.op = OP_WHITEN;
      ST_ROUND:    cmd.op = OP_ROUND;
      ST_FINAL:    if (out_free) cmd.op = OP_FINAL;
      default:     cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      step_r        <= STEP_M0;
      cycle_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      step_r        <= step_nxt;
      cycle_valid_r <= cycle_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rule30_feistel_block_cipher.sv -----
// Rule-30 Feistel block cipher top level; depends on r30fc_pkg, r30fc_ctrl, r30fc_dp.
// The key cycle is rederived when new_message is set, or for the first block after reset.
// One round-function unit is used once per cycle for key mixing, stirring, the 36
// schedule steps and the 32 rounds; whitening does not use it.
// Blocks are taken one at a time (input only in idle); the result register frees input.
// Reset (rst_n low, synchronous): key words and mode cleared, no key cycle held.
`timescale 1ns / 1ps
`default_nettype none

`include "rule30_feistel_block_cipher_defines.svh"

module rule30_feistel_block_cipher (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [r30fc_pkg::BLOCK_W-1:0]      in_tdata,   // [63:0] data_block
  input  wire                               in_tuser,   // [0] new_message
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [r30fc_pkg::BLOCK_W-1:0]     out_tdata,  // [63:0] result_block
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [r30fc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [r30fc_pkg::KEY_W-1:0]        cfg_data
);
  import r30fc_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  r30fc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  r30fc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_block     (in_tdata),
    .cmd          (cmd),
    .result_block (out_tdata)
  );

  `R30FC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `R30FC_ASSERT_IMP(a_final_needs_slot, clk, rst_n, cmd.op == OP_FINAL, !out_tvalid || out_tready)
  `R30FC_ASSERT_IMP(a_out_from_final, clk, rst_n, $rose(out_tvalid), $past(cmd.op == OP_FINAL))

endmodule

`default_nettype wire
